// ----- design/lpsc_pkg.sv -----
// lpsc_pkg: shared types and constants of the length-prefix to start-code converter
// no dependencies; used by every module of the block

package lpsc_pkg;

    localparam int unsigned MAX_SAMPLE_BYTES_DEF = 16777216;
    localparam int unsigned LEN_W                = 25;
    localparam int unsigned QUEUE_DEPTH          = 8;
    localparam int unsigned SC_LEN               = 4;

    localparam logic [7:0] START_CODE [SC_LEN] = '{8'h00, 8'h00, 8'h00, 8'h01};

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_STOPPED = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             sample_first;
        logic [LEN_W-1:0] sample_length;
    } in_word_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             run_last;
        logic             nal_begin;
        logic [LEN_W-1:0] bytes_written;
    } out_word_t;

    // one queued command: a start-code burst or a single payload byte
    typedef struct packed {
        logic             is_start;
        logic [7:0]       data;
        logic [LEN_W-1:0] count;
    } cmd_t;

endpackage

// ----- design/length_prefix_to_start_code_top.sv -----
// length_prefix_to_start_code_top: converts length-prefixed NAL units to start codes
// depends on lpsc_pkg, lpsc_front, lpsc_queue, lpsc_back
//
// usage
//   input queue side: drive item and push; a word is taken when push is high and full low.
//   one word is one byte of a sample; sample_first marks its first byte and
//   sample_length gives the sample size.
//   result queue side: while empty is low the oldest word is on result; pop takes it.
//   each 4-byte length prefix becomes 00 00 00 01, payload bytes pass through,
//   bad lengths and bytes past the sample end give no words.
//   a payload byte passes the command queue and the output register before it shows on result.
//   throughput: one input word per cycle while full is low; one output word per cycle
//   while pop is high; the queue between parser and emitter buffers each start code.
//   when pop stays low the output register and queue fill and full rises.
//   reset: parser waits for a sample start, queue and output register are emptied.

module length_prefix_to_start_code_top #(
    parameter int unsigned MAX_SAMPLE_BYTES = lpsc_pkg::MAX_SAMPLE_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH      = lpsc_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lpsc_pkg::in_word_t  item,
    input  logic                push,
    output logic                full,
    output lpsc_pkg::out_word_t result,
    output logic                empty,
    input  logic                pop
);

    lpsc_pkg::cmd_t cmd;
    lpsc_pkg::cmd_t head;
    logic           cmd_push;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;

    lpsc_front #(
        .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .push     (push),
        .full     (full),
        .cmd      (cmd),
        .cmd_push (cmd_push),
        .q_full   (q_full)
    );

    lpsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_cmd  (cmd),
        .wr_en   (cmd_push),
        .q_full  (q_full),
        .head    (head),
        .q_empty (q_empty),
        .rd_en   (q_pop)
    );

    lpsc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

// ----- design/lpsc_front.sv -----
// lpsc_front: parses the length prefixes of each sample and issues commands
// depends on lpsc_pkg

module lpsc_front #(
    parameter int unsigned MAX_SAMPLE_BYTES = lpsc_pkg::MAX_SAMPLE_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lpsc_pkg::in_word_t item,
    input  logic              push,
    output logic              full,
    output lpsc_pkg::cmd_t    cmd,
    output logic              cmd_push,
    input  logic              q_full
);

    localparam int unsigned LW = lpsc_pkg::LEN_W;
    localparam logic [31:0] MAX_W = 32'(MAX_SAMPLE_BYTES);

    lpsc_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [1:0]    pc_reg, pc_next, pc_eff;
    logic [23:0]   acc_reg, acc_next, acc_eff;
    logic [LW-1:0] left_reg, left_next, left_eff;
    logic [LW-1:0] offset_reg, offset_next, offset_eff;
    logic [LW-1:0] total_reg, total_next, total_eff;
    logic [LW-1:0] emitted_reg, emitted_next, emitted_eff;

    logic          accept;
    logic [LW-1:0] len_clamped;
    logic [31:0]   full_len;
    logic [LW-1:0] offset_inc;
    logic [32:0]   len_end;
    logic          emit_start;
    logic          emit_pay;

    assign accept = push && !q_full;
    assign full   = q_full;

    // state as seen by this word, after a sample start
    always_comb
    begin
        if ({7'b0, item.sample_length} > MAX_W)
        begin
            len_clamped = MAX_W[LW-1:0];
        end
        else
        begin
            len_clamped = item.sample_length;
        end
        if (item.sample_first)
        begin
            phase_eff   = lpsc_pkg::PH_HEADER;
            pc_eff      = 2'd0;
            acc_eff     = 24'd0;
            left_eff    = '0;
            offset_eff  = '0;
            total_eff   = len_clamped;
            emitted_eff = '0;
        end
        else
        begin
            phase_eff   = phase_reg;
            pc_eff      = pc_reg;
            acc_eff     = acc_reg;
            left_eff    = left_reg;
            offset_eff  = offset_reg;
            total_eff   = total_reg;
            emitted_eff = emitted_reg;
        end
    end

    // next state
    always_comb
    begin
        full_len     = {acc_eff, item.data_byte};
        offset_inc   = offset_eff + 1'b1;
        len_end      = {8'b0, offset_inc} + {1'b0, full_len};
        phase_next   = phase_eff;
        pc_next      = pc_eff;
        acc_next     = acc_eff;
        left_next    = left_eff;
        offset_next  = offset_eff;
        total_next   = total_eff;
        emitted_next = emitted_eff;
        emit_start   = 1'b0;
        emit_pay     = 1'b0;
        unique case (phase_eff)
            lpsc_pkg::PH_STOPPED:
            begin
                phase_next = lpsc_pkg::PH_STOPPED;
            end
            lpsc_pkg::PH_HEADER, lpsc_pkg::PH_PAYLOAD:
            begin
                if (offset_eff >= total_eff)
                begin
                    phase_next = lpsc_pkg::PH_STOPPED;
                end
                else
                begin
                    offset_next = offset_inc;
                    if (phase_eff == lpsc_pkg::PH_HEADER)
                    begin
                        if (pc_eff != 2'd3)
                        begin
                            pc_next  = pc_eff + 2'd1;
                            acc_next = {acc_eff[15:0], item.data_byte};
                        end
                        else
                        begin
                            pc_next  = 2'd0;
                            acc_next = 24'd0;
                            if (full_len == 32'd0 || len_end > {8'b0, total_eff})
                            begin
                                phase_next = lpsc_pkg::PH_STOPPED;
                            end
                            else
                            begin
                                emit_start   = 1'b1;
                                left_next    = full_len[LW-1:0];
                                phase_next   = lpsc_pkg::PH_PAYLOAD;
                                emitted_next = emitted_eff + LW'(lpsc_pkg::SC_LEN);
                            end
                        end
                    end
                    else
                    begin
                        emit_pay     = 1'b1;
                        left_next    = left_eff - 1'b1;
                        emitted_next = emitted_eff + 1'b1;
                        if (left_eff == LW'(1))
                        begin
                            phase_next = lpsc_pkg::PH_HEADER;
                        end
                    end
                    if (offset_inc >= total_eff)
                    begin
                        phase_next = lpsc_pkg::PH_STOPPED;
                    end
                end
            end
            default:
            begin
                phase_next = lpsc_pkg::PH_STOPPED;
            end
        endcase
    end

    // command output
    always_comb
    begin
        cmd_push     = accept && (emit_start || emit_pay);
        cmd.is_start = emit_start;
        cmd.data     = item.data_byte;
        cmd.count    = emitted_eff + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= lpsc_pkg::PH_STOPPED;
            pc_reg      <= 2'd0;
            acc_reg     <= 24'd0;
            left_reg    <= '0;
            offset_reg  <= '0;
            total_reg   <= '0;
            emitted_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            pc_reg      <= pc_next;
            acc_reg     <= acc_next;
            left_reg    <= left_next;
            offset_reg  <= offset_next;
            total_reg   <= total_next;
            emitted_reg <= emitted_next;
        end
    end

endmodule

// ----- design/lpsc_queue.sv -----
// lpsc_queue: small command queue between parser and byte emitter
// depends on lpsc_pkg

module lpsc_queue #(
    parameter int unsigned DEPTH = lpsc_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  lpsc_pkg::cmd_t wr_cmd,
    input  logic           wr_en,
    output logic           q_full,
    output lpsc_pkg::cmd_t head,
    output logic           q_empty,
    input  logic           rd_en
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    lpsc_pkg::cmd_t mem [DEPTH];
    logic [AW-1:0]  wp_reg, rp_reg;
    logic [CW-1:0]  cnt_reg;
    logic           do_wr, do_rd;

    assign q_full  = (cnt_reg == CW'(DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign head    = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wp_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// ----- design/lpsc_back.sv -----
// lpsc_back: expands queued commands into output words behind an output register
// depends on lpsc_pkg

module lpsc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lpsc_pkg::cmd_t      head,
    input  logic                q_empty,
    output logic                q_pop,
    output lpsc_pkg::out_word_t result,
    output logic                empty,
    input  logic                pop
);

    localparam logic [1:0] LAST_IDX = 2'(lpsc_pkg::SC_LEN - 1);

    logic                out_valid_reg;
    lpsc_pkg::out_word_t out_reg, out_next;
    logic [1:0]          idx_reg;
    logic                load;
    logic                done;

    assign load   = (!out_valid_reg || pop) && !q_empty;
    assign done   = !head.is_start || (idx_reg == LAST_IDX);
    assign q_pop  = load && done;
    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        out_next.out_byte      = head.is_start ? lpsc_pkg::START_CODE[idx_reg] : head.data;
        out_next.run_last      = done;
        out_next.nal_begin     = head.is_start && (idx_reg == 2'd0);
        out_next.bytes_written = head.count + {23'b0, idx_reg};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= done ? 2'd0 : idx_reg + 2'd1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- verif/tb_length_prefix_to_start_code_top.sv -----
// tb_length_prefix_to_start_code_top: self-checking testbench for the length-prefix to
// start-code converter, with directed samples, random traffic and random stalls on both sides
// depends on lpsc_pkg and length_prefix_to_start_code_top
`timescale 1ns / 1ps

module tb_length_prefix_to_start_code_top;

    localparam int IDLE_LIMIT  = 3000;
    localparam int RAND_ITEMS  = 170;
    localparam int HOLD_CYCLES = 300;

    logic                clk;
    logic                rst_n;
    lpsc_pkg::in_word_t  item;
    logic                push;
    logic                full;
    lpsc_pkg::out_word_t result;
    logic                empty;
    logic                pop;

    lpsc_pkg::out_word_t pending_out[$];
    logic [7:0]  smp_buf[$];
    int          err_count;
    int          live_count;
    bit          tx_jitter;
    bit          rx_jitter;
    int          rx_hold_len;

    lpsc_pkg::phase_t cv_phase;
    logic [1:0]  cv_prefix_cnt;
    logic [31:0] cv_len_acc;
    logic [31:0] cv_nal_left;
    logic [24:0] cv_pos;
    logic [24:0] cv_total;
    logic [24:0] cv_emitted;

    length_prefix_to_start_code_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .push   (push),
        .full   (full),
        .result (result),
        .empty  (empty),
        .pop    (pop)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
        err_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void add_out_word(input logic [7:0] b, input logic last_one,
                                         input logic sc_first);
        lpsc_pkg::out_word_t o;
        cv_emitted = cv_emitted + 25'd1;
        o.out_byte      = b;
        o.run_last      = last_one;
        o.nal_begin     = sc_first;
        o.bytes_written = cv_emitted;
        pending_out.push_back(o);
    endfunction

    // returns 1 when the byte was consumed by an active sample
    function automatic bit convert_byte(input lpsc_pkg::in_word_t w);
        logic [24:0] len;
        logic [33:0] nal_end;
        len = w.sample_length;
        if (w.sample_first)
        begin
            if (len > 25'(lpsc_pkg::MAX_SAMPLE_BYTES_DEF))
                len = 25'(lpsc_pkg::MAX_SAMPLE_BYTES_DEF);
            cv_total      = len;
            cv_pos        = '0;
            cv_phase      = lpsc_pkg::PH_HEADER;
            cv_prefix_cnt = '0;
            cv_len_acc    = '0;
            cv_nal_left   = '0;
            cv_emitted    = '0;
        end
        if (cv_phase == lpsc_pkg::PH_STOPPED)
            return 1'b0;
        if (cv_pos >= cv_total)
        begin
            cv_phase = lpsc_pkg::PH_STOPPED;
            return 1'b0;
        end
        cv_pos = cv_pos + 25'd1;
        if (cv_phase == lpsc_pkg::PH_HEADER)
        begin
            cv_len_acc = {cv_len_acc[23:0], w.data_byte};
            if (cv_prefix_cnt < 2'd3)
                cv_prefix_cnt = cv_prefix_cnt + 2'd1;
            else
            begin
                cv_prefix_cnt = '0;
                nal_end = 34'(cv_pos) + 34'(cv_len_acc);
                if (cv_len_acc == 32'd0 || nal_end > 34'(cv_total))
                    cv_phase = lpsc_pkg::PH_STOPPED;
                else
                begin
                    for (int i = 0; i < lpsc_pkg::SC_LEN; i++)
                        add_out_word(lpsc_pkg::START_CODE[i], i == lpsc_pkg::SC_LEN - 1,
                                     i == 0);
                    cv_nal_left = cv_len_acc;
                    cv_phase    = lpsc_pkg::PH_PAYLOAD;
                end
                cv_len_acc = '0;
            end
        end
        else
        begin
            add_out_word(w.data_byte, 1'b1, 1'b0);
            cv_nal_left = cv_nal_left - 32'd1;
            if (cv_nal_left == 32'd0)
                cv_phase = lpsc_pkg::PH_HEADER;
        end
        if (cv_pos >= cv_total)
            cv_phase = lpsc_pkg::PH_STOPPED;
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic is_first, input logic [24:0] len);
        lpsc_pkg::in_word_t w;
        int gap;
        w.data_byte     = b;
        w.sample_first  = is_first;
        w.sample_length = len;
        item <= w;
        push <= 1'b1;
        do
            @(posedge clk);
        while (full);
        live_count += convert_byte(w);
        gap = tx_jitter ? pick_gap() : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending_out.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_prefix(input logic [31:0] v);
        for (int i = 3; i >= 0; i--)
            smp_buf.push_back(v[8*i +: 8]);
    endtask

    task automatic add_nal(input int unsigned len);
        add_prefix(len);
        repeat (len) smp_buf.push_back(8'($urandom));
    endtask

    task automatic send_sample(input logic [24:0] declared);
        foreach (smp_buf[i])
            send_byte(smp_buf[i], i == 0, (i == 0) ? declared : 25'($urandom));
        smp_buf.delete();
    endtask

    function automatic int unsigned pick_nal_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // result side: check each popped word, then choose pop for the next cycle
    initial
    begin : result_checker
        int stall;
        lpsc_pkg::out_word_t want;
        stall = 0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (pending_out.size() == 0)
                    report_mismatch("unexpected word", 64'(result), 64'd0);
                else
                begin
                    want = pending_out.pop_front();
                    if (result.out_byte !== want.out_byte)
                        report_mismatch("out_byte", 64'(result.out_byte),
                                        64'(want.out_byte));
                    if (result.run_last !== want.run_last)
                        report_mismatch("run_last", 64'(result.run_last),
                                        64'(want.run_last));
                    if (result.nal_begin !== want.nal_begin)
                        report_mismatch("nal_begin", 64'(result.nal_begin),
                                        64'(want.nal_begin));
                    if (result.bytes_written !== want.bytes_written)
                        report_mismatch("bytes_written", 64'(result.bytes_written),
                                        64'(want.bytes_written));
                end
            end
            if (rx_hold_len > 0)
            begin
                stall = rx_hold_len;
                rx_hold_len = 0;
            end
            else if (stall == 0 && rx_jitter)
                stall = pick_gap();
            if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                idle = 0;
            else
                idle++;
        end
        $display("tb_length_prefix_to_start_code_top: errors");
        $finish;
    end

    task automatic test_idle_bytes();
        send_byte(8'hA5, 1'b0, 25'h1FF_FFFF);
    endtask

    task automatic test_nal_units();
        smp_buf = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'hFF,
                    8'h00, 8'h00, 8'h00, 8'h01, 8'h80, 8'h00, 8'h00};
        send_sample(25'd13);
        send_byte(8'h3C, 1'b0, 25'd0);
    endtask

    task automatic test_empty_sample();
        send_byte(8'h00, 1'b1, 25'd0);
    endtask

    task automatic test_bad_lengths();
        smp_buf = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00};
        send_sample(25'h1FF_FFFF);
        smp_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h11};
        send_sample(25'd5);
    endtask

    task automatic test_backpressure();
        int size;
        wait_drained();
        tx_jitter = 1'b0;
        rx_hold_len = HOLD_CYCLES;
        add_nal(40);
        add_nal(6);
        size = smp_buf.size();
        send_sample(25'(size));
        wait_drained();
    endtask

    task automatic rand_good_sample();
        int n;
        int size;
        n = $urandom_range(1, 4);
        repeat (n) add_nal(pick_nal_len());
        if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 3)) smp_buf.push_back(8'($urandom));
        size = smp_buf.size();
        case ($urandom_range(0, 9))
            0:       send_sample(25'($urandom_range(size, 33554431)));
            1:       send_sample(25'($urandom_range(1, size)));
            default: send_sample(25'(size));
        endcase
    endtask

    task automatic rand_bad_sample();
        int junk;
        logic [31:0] bad_len;
        repeat ($urandom_range(0, 2)) add_nal(pick_nal_len());
        junk = $urandom_range(0, 5);
        case ($urandom_range(0, 2))
            0:       bad_len = 32'd0;
            1:       bad_len = 32'(junk + $urandom_range(1, 4));
            default: bad_len = $urandom | 32'h0100_0000;
        endcase
        add_prefix(bad_len);
        repeat (junk) smp_buf.push_back(8'($urandom));
        send_sample(25'(smp_buf.size()));
    endtask

    task automatic test_random_traffic();
        int start;
        int r;
        start = live_count;
        while (live_count - start < RAND_ITEMS)
        begin
            tx_jitter = ($urandom_range(0, 3) != 0);
            rx_jitter = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 75)
                rand_good_sample();
            else if (r < 90)
                rand_bad_sample();
            else
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom), 1'b0, 25'($urandom));
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        push        = 1'b0;
        item        = '0;
        err_count   = 0;
        live_count  = 0;
        tx_jitter   = 1'b1;
        rx_jitter   = 1'b1;
        rx_hold_len = 0;
        cv_phase      = lpsc_pkg::PH_STOPPED;
        cv_prefix_cnt = '0;
        cv_len_acc    = '0;
        cv_nal_left   = '0;
        cv_pos        = '0;
        cv_total      = '0;
        cv_emitted    = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_bytes();
        test_nal_units();
        test_empty_sample();
        test_bad_lengths();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (20) @(posedge clk);
        if (pending_out.size() != 0)
            report_mismatch("words never seen", 64'(pending_out.size()), 64'd0);
        if (err_count == 0)
            $display("tb_length_prefix_to_start_code_top: clean");
        else
            $display("tb_length_prefix_to_start_code_top: errors");
        $finish;
    end

endmodule
